/* src/assert_macros.svh */
// Assertion macros shared by the priority queue RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/spq_pkg.sv */
// Types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue_core; depends on nothing.
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W     = 2;
    localparam int FIELD_W  = 32;
    localparam int SLOT_W   = 5;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT     = 2'd0,
        OP_EXTRACT    = 2'd1,
        OP_PEEK       = 2'd2,
        OP_CHANGE_KEY = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Command broadcast to every cell of the row.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_op_t;

endpackage

`default_nettype wire

/* src/sorted_priority_queue_core.sv */
// Sorted priority queue: a row of spq_cell slots kept in ascending priority.
// Depends on spq_pkg, spq_cell and assert_macros.svh.
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  in      | in_valid in_ready operation item_value         | in
//          | item_priority slot_position                    |
//  out     | out_valid out_ready out_value out_priority     | out
//          | entry_count status                             |
//
// Insert and extract update the cell row in the transfer cycle; peek reads
// the head. The result is registered and shows in the next cycle. Change
// key removes the entry at the slot, then reinserts it with the new key.
// A new item is taken once the row is idle and the output register is free
// or being emptied; a stalled result holds. Reset clears all valid bits and
// the count in one step; entry payloads need no reset.
`default_nettype none
`include "assert_macros.svh"

module sorted_priority_queue_core #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [spq_pkg::OP_W-1:0]      operation,
    input  wire logic signed [spq_pkg::FIELD_W-1:0] item_value,
    input  wire logic signed [spq_pkg::FIELD_W-1:0] item_priority,
    input  wire logic [spq_pkg::SLOT_W-1:0]    slot_position,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [spq_pkg::FIELD_W-1:0] out_value,
    output logic signed [spq_pkg::FIELD_W-1:0] out_priority,
    output logic [spq_pkg::COUNT_W-1:0]        entry_count,
    output logic [spq_pkg::STATUS_W-1:0]       status
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > spq_pkg::SLOT_W) ? CNT_W : spq_pkg::SLOT_W;

    typedef enum logic {
        S_IDLE,
        S_REINS
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [CNT_W-1:0]        occ_reg;
    logic [CNT_W-1:0]        occ_next;
    logic [DATA_WIDTH-1:0]   kept_val_reg;
    logic [DATA_WIDTH-1:0]   kept_val_next;
    logic [DATA_WIDTH-1:0]   kept_pri_reg;
    logic [DATA_WIDTH-1:0]   kept_pri_next;

    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic signed [spq_pkg::FIELD_W-1:0]   out_value_reg;
    logic signed [spq_pkg::FIELD_W-1:0]   out_value_next;
    logic signed [spq_pkg::FIELD_W-1:0]   out_priority_reg;
    logic signed [spq_pkg::FIELD_W-1:0]   out_priority_next;
    logic [spq_pkg::COUNT_W-1:0]          entry_count_reg;
    logic [spq_pkg::COUNT_W-1:0]          entry_count_next;
    logic [spq_pkg::STATUS_W-1:0]         status_reg;
    logic [spq_pkg::STATUS_W-1:0]         status_next;

    logic                  accept;
    logic                  res_load;
    spq_pkg::op_t          op_in;
    spq_pkg::cell_op_t     cell_cmd;
    logic [IDX_W-1:0]      cell_pos;
    logic [DATA_WIDTH-1:0] cell_new_val;
    logic [DATA_WIDTH-1:0] cell_new_pri;
    logic [DATA_WIDTH-1:0] in_val;
    logic [DATA_WIDTH-1:0] in_pri;
    logic                  is_full;
    logic                  is_empty;
    logic                  slot_bad;

    logic [DATA_WIDTH-1:0] cell_val [DEPTH];
    logic [DATA_WIDTH-1:0] cell_pri [DEPTH];
    logic [DEPTH-1:0]      cell_valid;
    logic [DEPTH-1:0]      cell_le;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign op_in    = spq_pkg::op_t'(operation);

    // Keep the low DATA_WIDTH bits, zero filled above 32.
    assign in_val = DATA_WIDTH'($unsigned(item_value));
    assign in_pri = DATA_WIDTH'($unsigned(item_priority));

    assign is_full  = (occ_reg == CNT_W'(DEPTH));
    assign is_empty = (occ_reg == '0);
    assign slot_bad = (CMP_W'(slot_position) >= CMP_W'(occ_reg));

    always_comb
    begin
        state_next        = state_reg;
        occ_next          = occ_reg;
        kept_val_next     = kept_val_reg;
        kept_pri_next     = kept_pri_reg;
        cell_cmd          = spq_pkg::CELL_HOLD;
        cell_pos          = '0;
        cell_new_val      = in_val;
        cell_new_pri      = in_pri;
        res_load          = 1'b0;
        out_value_next    = '0;
        out_priority_next = '0;
        status_next       = spq_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op_in)
                        spq_pkg::OP_INSERT:
                        begin
                            res_load = 1'b1;
                            if (is_full)
                            begin
                                status_next = spq_pkg::ST_FULL;
                            end
                            else
                            begin
                                cell_cmd = spq_pkg::CELL_INSERT;
                                occ_next = occ_reg + 1'b1;
                            end
                        end
                        spq_pkg::OP_EXTRACT,
                        spq_pkg::OP_PEEK:
                        begin
                            res_load = 1'b1;
                            if (is_empty)
                            begin
                                status_next = spq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                out_value_next    = spq_pkg::FIELD_W'($signed(cell_val[0]));
                                out_priority_next = spq_pkg::FIELD_W'($signed(cell_pri[0]));
                                if (op_in == spq_pkg::OP_EXTRACT)
                                begin
                                    cell_cmd = spq_pkg::CELL_REMOVE;
                                    occ_next = occ_reg - 1'b1;
                                end
                            end
                        end
                        spq_pkg::OP_CHANGE_KEY:
                        begin
                            if (slot_bad)
                            begin
                                res_load    = 1'b1;
                                status_next = spq_pkg::ST_RANGE;
                            end
                            else
                            begin
                                // pull the entry out, reinsert next cycle
                                cell_pos      = IDX_W'(slot_position);
                                cell_cmd      = spq_pkg::CELL_REMOVE;
                                occ_next      = occ_reg - 1'b1;
                                kept_val_next = cell_val[cell_pos];
                                kept_pri_next = in_pri;
                                state_next    = S_REINS;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_REINS:
            begin
                cell_cmd     = spq_pkg::CELL_INSERT;
                cell_new_val = kept_val_reg;
                cell_new_pri = kept_pri_reg;
                occ_next     = occ_reg + 1'b1;
                res_load     = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        entry_count_next = spq_pkg::COUNT_W'(occ_next);
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] l_val;
            logic [DATA_WIDTH-1:0] l_pri;
            logic                  l_valid;
            logic                  l_le;
            logic [DATA_WIDTH-1:0] r_val;
            logic [DATA_WIDTH-1:0] r_pri;
            logic                  r_valid;

            if (gi == 0)
            begin : g_head
                // the head always takes a new entry that outranks it
                assign l_val   = '0;
                assign l_pri   = '0;
                assign l_valid = 1'b0;
                assign l_le    = 1'b1;
            end
            else
            begin : g_body
                assign l_val   = cell_val[gi-1];
                assign l_pri   = cell_pri[gi-1];
                assign l_valid = cell_valid[gi-1];
                assign l_le    = cell_le[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign r_val   = '0;
                assign r_pri   = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_next
                assign r_val   = cell_val[gi+1];
                assign r_pri   = cell_pri[gi+1];
                assign r_valid = cell_valid[gi+1];
            end

            spq_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .IDX_W      (IDX_W),
                .INDEX      (gi)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cell_cmd),
                .pos         (cell_pos),
                .new_val     (cell_new_val),
                .new_pri     (cell_new_pri),
                .left_val    (l_val),
                .left_pri    (l_pri),
                .left_valid  (l_valid),
                .left_le     (l_le),
                .right_val   (r_val),
                .right_pri   (r_pri),
                .right_valid (r_valid),
                .val         (cell_val[gi]),
                .pri         (cell_pri[gi]),
                .valid       (cell_valid[gi]),
                .le          (cell_le[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kept_val_reg <= kept_val_next;
        kept_pri_reg <= kept_pri_next;
        if (res_load)
        begin
            out_value_reg    <= out_value_next;
            out_priority_reg <= out_priority_next;
            entry_count_reg  <= entry_count_next;
            status_reg       <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_value    = out_value_reg;
    assign out_priority = out_priority_reg;
    assign entry_count  = entry_count_reg;
    assign status       = status_reg;

    `SPQ_ASSERT_NOW(a_occ_bound, clk, rst_n, 1'b1, occ_reg <= CNT_W'(DEPTH), "occupancy above depth")
    `SPQ_ASSERT_NOW(a_valid_count, clk, rst_n, 1'b1, $countones(cell_valid) == int'(occ_reg), "valid cells disagree with occupancy")
    `SPQ_ASSERT_NOW(a_head_sorted, clk, rst_n, cell_valid[1], $signed(cell_pri[0]) <= $signed(cell_pri[1]), "front entries out of order")
    `SPQ_ASSERT_NEXT(a_reinsert, clk, rst_n, state_reg == S_REINS, state_reg == S_IDLE && out_valid_reg, "change key did not finish")

endmodule

`default_nettype wire

/* src/spq_cell.sv */
// One slot of the sorted row: holds a (value, priority) entry and a valid bit.
// Depends on spq_pkg; instantiated in a chain by sorted_priority_queue_core.
`default_nettype none

module spq_cell #(
    parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEF,
    parameter int IDX_W      = 5,
    parameter int INDEX      = 0
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire spq_pkg::cell_op_t     cmd,
    input  wire logic [IDX_W-1:0]      pos,
    input  wire logic [DATA_WIDTH-1:0] new_val,
    input  wire logic [DATA_WIDTH-1:0] new_pri,
    input  wire logic [DATA_WIDTH-1:0] left_val,
    input  wire logic [DATA_WIDTH-1:0] left_pri,
    input  wire logic                  left_valid,
    input  wire logic                  left_le,
    input  wire logic [DATA_WIDTH-1:0] right_val,
    input  wire logic [DATA_WIDTH-1:0] right_pri,
    input  wire logic                  right_valid,
    output logic [DATA_WIDTH-1:0]      val,
    output logic [DATA_WIDTH-1:0]      pri,
    output logic                       valid,
    output logic                       le
);

    logic [DATA_WIDTH-1:0] val_reg;
    logic [DATA_WIDTH-1:0] val_next;
    logic [DATA_WIDTH-1:0] pri_reg;
    logic [DATA_WIDTH-1:0] pri_next;
    logic                  valid_reg;
    logic                  valid_next;

    // Entry stays ahead of a new one of the same or larger priority.
    assign le = valid_reg && ($signed(pri_reg) <= $signed(new_pri));

    always_comb
    begin
        val_next   = val_reg;
        pri_next   = pri_reg;
        valid_next = valid_reg;
        case (cmd)
            spq_pkg::CELL_INSERT:
            begin
                if (!le)
                begin
                    if (left_le)
                    begin
                        // new entry lands here
                        val_next   = new_val;
                        pri_next   = new_pri;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        // shift one place back
                        val_next   = left_val;
                        pri_next   = left_pri;
                        valid_next = left_valid;
                    end
                end
            end
            spq_pkg::CELL_REMOVE:
            begin
                if (IDX_W'(INDEX) >= pos)
                begin
                    val_next   = right_val;
                    pri_next   = right_pri;
                    valid_next = right_valid;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        pri_reg <= pri_next;
    end

    assign val   = val_reg;
    assign pri   = pri_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire
